// ----- rtl/core/vaps_pkg.sv -----
// Shared types and constants of the voice allocator with priority stealing.
// Depends on nothing; the top level imports it.
`timescale 1ns / 1ps

package vaps_pkg;

    localparam int NUM_VOICES_DEF  = 16;
    localparam int NUM_SAMPLES_DEF = 256;

    localparam int CMD_W   = 2;
    localparam int ID_W    = 8;
    localparam int VOICE_W = 4;
    localparam int LIMIT_W = 4;
    localparam int FLAG_W  = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    // configuration register indexes
    localparam logic REG_DUP_ONESHOT = 1'b0;
    localparam logic REG_DUP_LOOPING = 1'b1;

    localparam logic [LIMIT_W-1:0] DUP_ONESHOT_RST = 4'd2;
    localparam logic [LIMIT_W-1:0] DUP_LOOPING_RST = 4'd1;
    localparam logic [LIMIT_W-1:0] USAGE_MAX       = 4'd15;

    // owner flag bit positions
    localparam int FL_LOOP = 0;
    localparam int FL_OFF  = 1;
    localparam int FL_DIST = 2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    sample_id;
        logic               req_looping;
        logic               req_offscreen;
        logic               req_distant;
        logic [VOICE_W-1:0] start_voice;
        logic [VOICE_W-1:0] target_voice;
    } t_req;

    typedef struct packed {
        logic               granted;
        logic [VOICE_W-1:0] voice;
        logic               stolen;
        logic               reload;
        logic               duplicate;
    } t_rsp;

endpackage

// ----- rtl/core/voice_allocator_priority_steal.sv -----
// Top level of the voice allocator with priority stealing: sequencer, voice
// table, voice ring and the per-sample usage store. Uses vaps_pkg, vaps_ram.
`timescale 1ns / 1ps

// Usage
//   Request channel (i_req_valid / o_req_stall / i_req): one beat is one
//   command: allocate, release a voice, or update a voice's owner flags.
//   Response channel (o_rsp_valid / i_rsp_stall / o_rsp): exactly one beat
//   comes back for every request beat, in order.
//   Configuration: i_cfg_we writes i_cfg_data into the duplicate limit named
//   by i_cfg_idx; write only while the block is idle.
//   Timing: the block works on one request at a time and stalls the request
//   channel until the response is handed to the output register. Release,
//   update, invalid and unused commands go straight to the response. An
//   allocation brings start_voice into range (no step when it is below
//   NUM_VOICES), reads the usage store, walks the voice ring one voice per
//   cycle through the shared compare unit and picks a voice; a granted
//   allocation then updates the usage store and relinks the ring when the
//   voice was not already at the ring head.
//   Reset: voice table and ring return to their initial order; the usage
//   store is then cleared one entry a cycle, during which requests are
//   stalled (configuration writes still land).
//   A stalled response holds in the output register; a finished response
//   behind it waits in the sequencer and the request channel stays stalled.

module voice_allocator_priority_steal #(
    parameter int NUM_VOICES  = vaps_pkg::NUM_VOICES_DEF,
    parameter int NUM_SAMPLES = vaps_pkg::NUM_SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_stall,
    input  vaps_pkg::t_req                i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_stall,
    output vaps_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [vaps_pkg::LIMIT_W-1:0]  i_cfg_data
);

    import vaps_pkg::*;

    localparam int VW = $clog2(NUM_VOICES);
    localparam int SW = $clog2(NUM_SAMPLES);
    localparam logic [VW-1:0] NV_LAST  = VW'(NUM_VOICES - 1);
    localparam logic [SW-1:0] NS_LAST  = SW'(NUM_SAMPLES - 1);
    // voice count seen from a 4-bit index; anything at or above 16 never wraps
    localparam logic [VOICE_W:0] NV_CAP = (NUM_VOICES > 15) ? 5'd16 : 5'(NUM_VOICES);

    // sequencer states
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_USE   = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_PICK  = 4'd5;
    localparam logic [3:0] S_OLD   = 4'd6;
    localparam logic [3:0] S_WRID  = 4'd7;
    localparam logic [3:0] S_LINK1 = 4'd8;
    localparam logic [3:0] S_LINK2 = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] r_state, n_state;

    // configuration
    logic [LIMIT_W-1:0] r_lim_one;
    logic [LIMIT_W-1:0] r_lim_loop;

    // request in work
    t_req               r_req;
    logic [VOICE_W-1:0] r_start;
    logic [VW-1:0]      r_v;
    logic [VW-1:0]      r_walk_start;
    logic [VW-1:0]      r_cnt;
    logic [LIMIT_W-1:0] r_usage_id;
    logic               r_under;
    logic               r_mu_ok, r_au_ok, r_mo_ok, r_ao_ok;
    logic [VW-1:0]      r_mu, r_au, r_mo, r_ao;
    logic [VW-1:0]      r_res_v;
    logic [SW-1:0]      r_clr;
    t_rsp               r_rsp;
    t_rsp               r_out;
    logic               r_out_valid;

    // voice table and ring
    logic               r_owned  [NUM_VOICES];
    logic               r_loaded [NUM_VOICES];
    logic [ID_W-1:0]    r_sample [NUM_VOICES];
    logic [FLAG_W-1:0]  r_flags  [NUM_VOICES];
    logic [VW-1:0]      r_next   [NUM_VOICES];
    logic [VW-1:0]      r_prev   [NUM_VOICES];
    logic [VW-1:0]      r_head;

    // usage store port
    logic               ram_we;
    logic [SW-1:0]      ram_waddr;
    logic [LIMIT_W-1:0] ram_wdata;
    logic [SW-1:0]      ram_raddr;
    logic [LIMIT_W-1:0] ram_rdata;

    logic               req_acc;
    logic [FLAG_W-1:0]  in_flags, rf;
    logic [LIMIT_W-1:0] limit;
    logic               id_valid;
    logic               start_ge;
    logic               tgt_ok;
    logic [VW+VOICE_W-1:0] start_ext, tgt_ext;
    logic [VW-1:0]      start_v, tgt_v;
    logic [SW+ID_W-1:0] id_ext, old_ext;
    logic [VW-1:0]      sel_v;
    logic               old_valid;
    logic               old_dec;
    logic               free_out;

    // walk compare unit
    logic               w_match;
    logic               w_mu, w_au, w_mo, w_ao;
    logic [FLAG_W-1:0]  w_mask, w_vf;

    // pick
    logic               pick_ok;
    logic [VW-1:0]      pick_v;
    logic [VOICE_W+VW-1:0] pick_ext;
    logic               pick_reload;

    assign req_acc     = i_req_valid && (r_state == S_IDLE);
    assign o_req_stall = (r_state != S_IDLE);
    assign free_out    = !r_out_valid || !i_rsp_stall;

    assign in_flags = {i_req.req_distant, i_req.req_offscreen, i_req.req_looping};
    assign rf       = {r_req.req_distant, r_req.req_offscreen, r_req.req_looping};
    assign limit    = r_req.req_looping ? r_lim_loop : r_lim_one;
    assign id_valid = (i_req.sample_id != '0) && (32'(i_req.sample_id) < NUM_SAMPLES);

    assign start_ge  = ({1'b0, r_start} >= NV_CAP);
    assign start_ext = {{VW{1'b0}}, r_start};
    assign start_v   = start_ext[VW-1:0];
    assign tgt_ok    = ({1'b0, i_req.target_voice} < NV_CAP);
    assign tgt_ext   = {{VW{1'b0}}, i_req.target_voice};
    assign tgt_v     = tgt_ext[VW-1:0];

    assign id_ext    = {{SW{1'b0}}, r_req.sample_id};
    assign sel_v     = (r_state == S_PICK) ? pick_v : r_res_v;
    assign old_ext   = {{SW{1'b0}}, r_sample[sel_v]};
    assign old_valid = (32'(r_sample[r_res_v]) < NUM_SAMPLES);
    assign old_dec   = r_rsp.reload && r_loaded[r_res_v] && old_valid && (ram_rdata != '0);

    // classify the voice under the walk pointer
    always_comb begin
        w_match = r_loaded[r_v] && (r_sample[r_v] == r_req.sample_id);
        w_mask  = rf[FL_OFF] ? FLAG_W'(1 << FL_DIST) : FLAG_W'(1 << FL_OFF);
        w_vf    = r_flags[r_v] & (w_mask | FLAG_W'(1 << FL_LOOP));
        w_mu    = 1'b0;
        w_au    = 1'b0;
        w_mo    = 1'b0;
        w_ao    = 1'b0;
        if (!r_owned[r_v]) begin
            w_mu = w_match;
            w_au = !w_match && r_under;
        end else if (!(rf[FL_OFF] && rf[FL_DIST])) begin
            if (rf[FL_LOOP] && (w_vf == (w_mask | FLAG_W'(1 << FL_LOOP)))) begin
                w_mo = w_match;
            end else if (w_vf == w_mask) begin
                w_mo = w_match;
                w_ao = !w_match && r_under;
            end
        end
    end

    // choose in order of preference
    always_comb begin
        pick_ok = 1'b1;
        pick_v  = r_mu;
        priority if (r_mu_ok) begin
            pick_v = r_mu;
        end else if (r_au_ok) begin
            pick_v = r_au;
        end else if (r_mo_ok) begin
            pick_v = r_mo;
        end else if (r_ao_ok) begin
            pick_v = r_ao;
        end else begin
            pick_ok = 1'b0;
        end
    end

    assign pick_ext    = {{VOICE_W{1'b0}}, pick_v};
    assign pick_reload = !(r_loaded[pick_v] && (r_sample[pick_v] == r_req.sample_id));

    // usage store access
    assign ram_raddr = (r_state == S_PICK) ? old_ext[SW-1:0] : id_ext[SW-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = id_ext[SW-1:0];
        ram_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_OLD: begin
                ram_we    = old_dec;
                ram_waddr = old_ext[SW-1:0];
                ram_wdata = ram_rdata - LIMIT_W'(1);
            end
            S_WRID: begin
                ram_we    = r_rsp.reload;
                ram_wdata = (r_usage_id == USAGE_MAX) ? r_usage_id
                                                      : r_usage_id + LIMIT_W'(1);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    vaps_ram #(
        .WIDTH (LIMIT_W),
        .DEPTH (NUM_SAMPLES)
    ) u_usage (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   n_state = (r_clr == NS_LAST) ? S_IDLE : S_CLR;
            S_IDLE: begin
                if (req_acc) begin
                    n_state = (i_req.cmd == CMD_ALLOC && id_valid) ? S_MOD : S_OUT;
                end
            end
            S_MOD:   n_state = start_ge ? S_MOD : S_USE;
            S_USE:   n_state = S_WALK;
            S_WALK:  n_state = (r_cnt == NV_LAST) ? S_PICK : S_WALK;
            S_PICK:  n_state = pick_ok ? S_OLD : S_OUT;
            S_OLD:   n_state = S_WRID;
            S_WRID:  n_state = (r_res_v == r_head) ? S_OUT : S_LINK1;
            S_LINK1: n_state = S_LINK2;
            S_LINK2: n_state = S_OUT;
            S_OUT:   n_state = free_out ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + SW'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_one  <= DUP_ONESHOT_RST;
            r_lim_loop <= DUP_LOOPING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DUP_ONESHOT: r_lim_one  <= i_cfg_data;
                REG_DUP_LOOPING: r_lim_loop <= i_cfg_data;
                default:         r_lim_one  <= r_lim_one;
            endcase
        end
    end

    // datapath of the request in work
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    r_req           <= i_req;
                    r_start         <= i_req.start_voice;
                    r_rsp.granted   <= 1'b0;
                    r_rsp.stolen    <= 1'b0;
                    r_rsp.reload    <= 1'b0;
                    r_rsp.duplicate <= 1'b0;
                    // release and update echo their target voice
                    r_rsp.voice     <= (i_req.cmd == CMD_RELEASE || i_req.cmd == CMD_UPDATE)
                                       ? i_req.target_voice : '0;
                end
            end
            S_MOD: begin
                // reduce the start voice into range one subtraction at a time
                if (start_ge) begin
                    r_start <= r_start - NV_CAP[VOICE_W-1:0];
                end else begin
                    r_v          <= start_v;
                    r_walk_start <= start_v;
                end
            end
            S_USE: begin
                r_usage_id <= ram_rdata;
                r_under    <= (ram_rdata < limit);
                r_cnt      <= '0;
                r_mu_ok    <= 1'b0;
                r_au_ok    <= 1'b0;
                r_mo_ok    <= 1'b0;
                r_ao_ok    <= 1'b0;
            end
            S_WALK: begin
                // keep the last voice seen in each class
                if (w_mu) begin
                    r_mu_ok <= 1'b1;
                    r_mu    <= r_v;
                end
                if (w_au) begin
                    r_au_ok <= 1'b1;
                    r_au    <= r_v;
                end
                if (w_mo) begin
                    r_mo_ok <= 1'b1;
                    r_mo    <= r_v;
                end
                if (w_ao) begin
                    r_ao_ok <= 1'b1;
                    r_ao    <= r_v;
                end
                r_v   <= r_next[r_v];
                r_cnt <= r_cnt + VW'(1);
            end
            S_PICK: begin
                if (pick_ok) begin
                    r_res_v         <= pick_v;
                    r_rsp.granted   <= 1'b1;
                    r_rsp.voice     <= pick_ext[VOICE_W-1:0];
                    r_rsp.stolen    <= r_owned[pick_v];
                    r_rsp.reload    <= pick_reload;
                    r_rsp.duplicate <= pick_reload ? (r_usage_id != '0)
                                                   : (r_usage_id > LIMIT_W'(1));
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // voice table and ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_owned[i]  <= 1'b0;
                r_loaded[i] <= 1'b0;
                r_sample[i] <= '0;
                r_flags[i]  <= '0;
                r_next[i]   <= VW'((i + 1) % NUM_VOICES);
                r_prev[i]   <= VW'((i + NUM_VOICES - 1) % NUM_VOICES);
            end
            r_head <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (req_acc && tgt_ok) begin
                        if (i_req.cmd == CMD_RELEASE) begin
                            r_owned[tgt_v] <= 1'b0;
                            r_flags[tgt_v] <= '0;
                        end else if (i_req.cmd == CMD_UPDATE && r_owned[tgt_v]) begin
                            r_flags[tgt_v] <= in_flags;
                        end
                    end
                end
                S_WRID: begin
                    r_owned[r_res_v]  <= 1'b1;
                    r_loaded[r_res_v] <= 1'b1;
                    r_sample[r_res_v] <= r_req.sample_id;
                    r_flags[r_res_v]  <= rf;
                end
                S_LINK1: begin
                    // unlink the granted voice
                    r_next[r_prev[r_res_v]] <= r_next[r_res_v];
                    r_prev[r_next[r_res_v]] <= r_prev[r_res_v];
                end
                S_LINK2: begin
                    // insert it in front of the old head
                    r_prev[r_res_v]         <= r_prev[r_head];
                    r_next[r_res_v]         <= r_head;
                    r_next[r_prev[r_head]]  <= r_res_v;
                    r_prev[r_head]          <= r_res_v;
                    r_head                  <= r_res_v;
                end
                default: begin
                    r_head <= r_head;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && free_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && free_out) begin
            r_out <= r_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // the ring is one closed cycle: a full walk comes back to its start
    a_walk_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_cnt == NV_LAST) |=> (r_v == r_walk_start))
        else $error("ring walk did not return to its start voice");

    // links around the head stay consistent between requests
    a_ring_links: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            (r_prev[r_next[r_head]] == r_head) && (r_next[r_prev[r_head]] == r_head))
        else $error("voice ring links broken at the head");

    // the usage store is left alone while the walk reads its snapshot
    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !ram_we)
        else $error("usage store written during the ring walk");

    // a refused beat carries no grant details
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.granted) |->
            (!o_rsp.stolen && !o_rsp.reload && !o_rsp.duplicate))
        else $error("response flags set without a grant");

    // a granted voice exists
    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.granted) |-> (32'(o_rsp.voice) < NUM_VOICES))
        else $error("granted voice index out of range");

endmodule

// ----- rtl/core/vaps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module vaps_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
